### sv/hrhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types, constants and lookup functions for the request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int LineBytes    = 1024;
   localparam int RequestBytes = 8192;
   localparam int FieldBytes   = 256;
   localparam int MethodBytes  = 15;

   localparam int NumHeaders   = 15;
   localparam int NumStrHdrs   = 13;
   localparam int NumCodings   = 5;
   localparam int NameMax      = 18;

   localparam logic [3:0] HdrContentLength    = 4'd13;
   localparam logic [3:0] HdrTransferEncoding = 4'd14;
   localparam logic [3:0] HdrNone             = 4'd15;

   typedef enum logic [2:0] {
      PH_REQLINE    = 3'd0,
      PH_LINE_START = 3'd1,
      PH_HEADER     = 3'd2,
      PH_BLANK_CR   = 3'd3,
      PH_DEAD       = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      K_TOKEN_BYTE = 3'd0,
      K_TOKEN_END  = 3'd1,
      K_VALUE_BYTE = 3'd2,
      K_VALUE_END  = 3'd3,
      K_DONE       = 3'd4,
      K_MALFORMED  = 3'd5,
      K_NONE       = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      NS_SKIP   = 2'd0,
      NS_DIGITS = 2'd1,
      NS_STOP   = 2'd2
   } num_scan_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  field_id;
      logic [7:0]  out_byte;
      logic [9:0]  value_length;
      logic [9:0]  value_start;
      logic [13:0] body_length;
      logic        chunked;
      logic        te_other;
      logic [13:0] body_offset;
   } rsp_type;

   function automatic logic [4:0] hdr_len(input logic [3:0] j);
      logic [4:0] n;
      unique case (j)
         4'd0:  n = 5'd5;
         4'd1:  n = 5'd11;
         4'd2:  n = 5'd8;
         4'd3:  n = 5'd7;
         4'd4:  n = 5'd7;
         4'd5:  n = 5'd16;
         4'd6:  n = 5'd13;
         4'd7:  n = 5'd11;
         4'd8:  n = 5'd14;
         4'd9:  n = 5'd14;
         4'd10: n = 5'd18;
         4'd11: n = 5'd7;
         4'd12: n = 5'd6;
         4'd13: n = 5'd15;
         4'd14: n = 5'd18;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   function automatic logic [8*NameMax-1:0] hdr_text(input logic [3:0] j);
      logic [8*NameMax-1:0] s;
      unique case (j)
         4'd0:  s = "host:";
         4'd1:  s = "user-agent:";
         4'd2:  s = "referer:";
         4'd3:  s = "origin:";
         4'd4:  s = "accept:";
         4'd5:  s = "accept-encoding:";
         4'd6:  s = "content-type:";
         4'd7:  s = "connection:";
         4'd8:  s = "authorization:";
         4'd9:  s = "if-none-match:";
         4'd10: s = "if-modified-since:";
         4'd11: s = "expect:";
         4'd12: s = "range:";
         4'd13: s = "content-length:";
         4'd14: s = "transfer-encoding:";
         default: s = '0;
      endcase
      return s;
   endfunction

   // character of a header name at a position counted from its first character
   function automatic logic [7:0] hdr_char(input logic [3:0] j, input logic [4:0] p);
      logic [8*NameMax-1:0] s;
      logic [4:0]           n;
      logic [4:0]           sh;
      s  = hdr_text(j);
      n  = hdr_len(j);
      sh = n - 5'd1 - p;
      return s[8*sh +: 8];
   endfunction

   function automatic logic [3:0] cod_len(input logic [2:0] j);
      logic [3:0] n;
      unique case (j)
         3'd0: n = 4'd7;
         3'd1: n = 4'd4;
         3'd2: n = 4'd7;
         3'd3: n = 4'd8;
         3'd4: n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [63:0] cod_text(input logic [2:0] j);
      logic [63:0] s;
      unique case (j)
         3'd0: s = "chunked";
         3'd1: s = "gzip";
         3'd2: s = "deflate";
         3'd3: s = "compress";
         3'd4: s = "identity";
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] cod_char(input logic [2:0] j, input logic [3:0] p);
      logic [63:0] s;
      logic [3:0]  sh;
      s  = cod_text(j);
      sh = cod_len(j) - 4'd1 - p;
      return s[8*sh[2:0] +: 8];
   endfunction

   // kmp style step over a short needle; none of the codings has a long border
   function automatic logic [3:0] cod_step(input logic [2:0] j, input logic [3:0] k,
                                           input logic [7:0] c);
      logic [3:0] res;
      logic       ok;
      res = 4'd0;
      for (int m = 1; m <= 9; m++) begin
         if (m <= int'(k) + 1 && m <= int'(cod_len(j))) begin
            ok = (cod_char(j, 4'(m - 1)) == c);
            for (int q = 0; q < 8; q++) begin
               if (q < m - 1 && cod_char(j, 4'(q)) != cod_char(j, 4'(int'(k) + 1 - m + q)))
                  ok = 1'b0;
            end
            if (ok) res = 4'(m);
         end
      end
      return res;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
   endfunction

endpackage

### sv/hrhp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_req_if / hrhp_rsp_if
// valid/ready channels for request beats and result beats
// ----------------------------------------------------------------------------
interface hrhp_req_if import hrhp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hrhp_rsp_if import hrhp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/http_request_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_unit
// byte-serial parser for an http/1.1 request line and header block
// ----------------------------------------------------------------------------
// One request byte is taken per clock and gives at most one result beat,
// registered in the output buffer. All parsing state updates together for
// each byte (header name matchers, value counters, content-length fold,
// coding matchers). A two-entry output buffer holds result beats while the
// result side stalls; input is held off only once both entries are full, so
// with the result side taking beats the sustained rate is one byte per cycle.
module http_request_header_parser_unit import hrhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hrhp_req_if.sink   req,
   hrhp_rsp_if.source rsp
);

   phase_type    phase_ff, phase_in;
   logic [13:0]  bcnt_ff, bcnt_in;
   logic [10:0]  lpos_ff, lpos_in;
   logic [14:0]  cand_ff, cand_in;
   logic [3:0]   hdr_ff, hdr_in;
   logic [1:0]   tok_ff, tok_in;
   logic [9:0]   raw_ff, raw_in;
   logic [9:0]   lead_ff, lead_in;
   logic [9:0]   lne_ff, lne_in;
   logic [14:0]  acc_ff, acc_in;
   num_scan_type ns_ff, ns_in;
   logic [13:0]  slen_ff, slen_in;
   logic [3:0]   cprog_ff [NumCodings];
   logic [3:0]   cprog_in [NumCodings];
   logic [4:0]   cfound_ff, cfound_in;
   logic         fchk_ff, fchk_in;
   logic         fte_ff, fte_in;
   logic         acr_ff, acr_in;

   // skid buffer
   rsp_type      buf_ff [2];
   logic [1:0]   cnt_ff;
   logic         rd_ff;
   logic         wr_ff;

   logic         take;
   logic         push;
   logic         pop;
   rsp_type      r;
   logic [7:0]   c;
   logic         last;

   assign req.ready = (cnt_ff != 2'd2);
   assign take      = req.valid && req.ready;
   assign c         = req.payload.data_byte;
   assign last      = req.payload.last_byte;

   always_comb begin
      logic [9:0]  pos;
      logic [7:0]  lc;
      logic        dig;
      logic [18:0] v;
      logic [10:0] lim;
      logic [2:0]  rk;
      phase_in  = phase_ff;
      bcnt_in   = bcnt_ff;
      lpos_in   = lpos_ff;
      cand_in   = cand_ff;
      hdr_in    = hdr_ff;
      tok_in    = tok_ff;
      raw_in    = raw_ff;
      lead_in   = lead_ff;
      lne_in    = lne_ff;
      acc_in    = acc_ff;
      ns_in     = ns_ff;
      slen_in   = slen_ff;
      cprog_in  = cprog_ff;
      cfound_in = cfound_ff;
      fchk_in   = fchk_ff;
      fte_in    = fte_ff;
      acr_in    = acr_ff;
      r         = '0;
      rk        = K_NONE;
      lc        = to_lower(c);
      dig       = c >= 8'h30 && c <= 8'h39;
      pos       = lpos_ff[9:0];
      v         = '0;
      lim       = '0;

      if (phase_ff != PH_DEAD) begin
         if (c == 8'd0 || {1'b0, bcnt_ff} >= 15'(RequestBytes)) begin
            if (phase_ff == PH_BLANK_CR) begin
               rk = K_DONE;
               r.body_offset = bcnt_ff;
            end else begin
               rk = K_MALFORMED;
            end
         end else begin
            unique case (phase_ff)
               PH_REQLINE: begin
                  if (c == 8'h0D || c == 8'h0A) begin
                     if (lpos_ff == 11'd0) rk = K_MALFORMED;
                     else if (tok_ff == 2'd2 && raw_ff != 10'd0) begin
                        rk = K_TOKEN_END;
                        r.field_id = 4'd2;
                        r.value_length = raw_ff;
                     end else if (tok_ff != 2'd3) rk = K_MALFORMED;
                     phase_in = PH_LINE_START;
                     acr_in   = (c == 8'h0D);
                  end else begin
                     if (lpos_ff < 11'(LineBytes)) lpos_in = lpos_ff + 11'd1;
                     if (lpos_ff < 11'(LineBytes)) begin
                        if (is_ws(c)) begin
                           if (raw_ff != 10'd0) begin
                              rk = K_TOKEN_END;
                              r.field_id = {2'b00, tok_ff};
                              r.value_length = raw_ff;
                              tok_in = tok_ff + 2'd1;
                              raw_in = '0;
                           end
                        end else if (tok_ff != 2'd3) begin
                           lim = (tok_ff == 2'd1) ? 11'(LineBytes - 1) : 11'(MethodBytes);
                           if ({1'b0, raw_ff} >= lim) rk = K_MALFORMED;
                           else begin
                              rk = K_TOKEN_BYTE;
                              r.field_id = {2'b00, tok_ff};
                              r.out_byte = c;
                              raw_in = raw_ff + 10'd1;
                           end
                        end
                     end
                  end
               end
               PH_BLANK_CR: begin
                  rk = K_DONE;
                  r.body_offset = (c == 8'h0A) ? bcnt_ff + 14'd1 : bcnt_ff;
               end
               PH_HEADER, PH_LINE_START: begin
                  logic content;
                  logic fresh;
                  content = 1'b0;
                  fresh   = 1'b0;
                  if (phase_ff == PH_HEADER) begin
                     if (c == 8'h0D || c == 8'h0A) begin
                        if (hdr_ff < 4'(NumStrHdrs)) begin
                           rk = K_VALUE_END;
                           r.field_id = hdr_ff;
                           r.value_length = (lne_ff > lead_ff) ? lne_ff - lead_ff : 10'd0;
                           r.value_start = lead_ff;
                        end else if (hdr_ff == HdrContentLength) begin
                           slen_in = (acc_ff != 15'd0 && acc_ff <= 15'(RequestBytes))
                                     ? acc_ff[13:0] : 14'd0;
                        end else if (hdr_ff == HdrTransferEncoding) begin
                           if (cfound_ff[0] && cfound_ff[4:1] == 4'd0) fchk_in = 1'b1;
                           else fte_in = 1'b1;
                        end
                        phase_in = PH_LINE_START;
                        acr_in   = (c == 8'h0D);
                     end else content = 1'b1;
                  end else if (acr_ff && c == 8'h0A) begin
                     acr_in = 1'b0;
                  end else begin
                     acr_in = 1'b0;
                     if (c == 8'h0D) begin
                        phase_in = PH_BLANK_CR;
                        if (last) begin
                           rk = K_DONE;
                           r.body_offset = bcnt_ff + 14'd1;
                        end
                     end else if (c == 8'h0A) begin
                        rk = K_DONE;
                        r.body_offset = bcnt_ff + 14'd1;
                     end else begin
                        content = 1'b1;
                        fresh   = 1'b1;
                     end
                  end
                  if (content) begin
                     logic [10:0] lp;
                     logic [3:0]  hh;
                     logic [14:0] cd;
                     logic [9:0]  rw;
                     logic [9:0]  ld;
                     logic [9:0]  ln;
                     logic [14:0] ac;
                     num_scan_type nsv;
                     logic [4:0]  cf;
                     lp = fresh ? 11'd0 : lpos_ff;
                     hh = fresh ? HdrNone : hdr_ff;
                     cd = fresh ? 15'h7FFF : cand_ff;
                     rw = fresh ? 10'd0 : raw_ff;
                     ld = fresh ? 10'd0 : lead_ff;
                     ln = fresh ? 10'd0 : lne_ff;
                     ac = fresh ? 15'd0 : acc_ff;
                     nsv = fresh ? NS_SKIP : ns_ff;
                     cf = fresh ? 5'd0 : cfound_ff;
                     if (fresh) begin
                        phase_in = PH_HEADER;
                        for (int j = 0; j < NumCodings; j++) cprog_in[j] = '0;
                     end
                     pos = lp[9:0];
                     lpos_in = (lp < 11'(LineBytes)) ? lp + 11'd1 : lp;
                     hdr_in = hh; cand_in = cd; raw_in = rw; lead_in = ld; lne_in = ln;
                     acc_in = ac; ns_in = nsv; cfound_in = cf;
                     if (lp < 11'(LineBytes - 1)) begin
                        if (hh == HdrNone) begin
                           for (int j = 0; j < NumHeaders; j++) begin
                              if (cd[j] && {1'b0, pos} < 11'(hdr_len(4'(j)))) begin
                                 if (lc != hdr_char(4'(j), pos[4:0])) cand_in[j] = 1'b0;
                                 else if (pos[4:0] == hdr_len(4'(j)) - 5'd1) hdr_in = 4'(j);
                              end
                           end
                        end else if (hh < 4'(NumStrHdrs)) begin
                           if (rw < 10'(FieldBytes - 1)) begin
                              if (!is_ws(c)) lne_in = rw + 10'd1;
                              else if (ln == 10'd0) lead_in = ld + 10'd1;
                              raw_in = rw + 10'd1;
                              rk = K_VALUE_BYTE;
                              r.field_id = hh;
                              r.out_byte = c;
                           end
                        end else if (hh == HdrContentLength) begin
                           unique case (nsv)
                              NS_SKIP: begin
                                 if (is_ws(c)) ;
                                 else if (c == 8'h2B) ns_in = NS_DIGITS;
                                 else if (dig) begin
                                    ns_in = NS_DIGITS;
                                    acc_in = {11'd0, c[3:0]};
                                 end else begin
                                    acc_in = '0;
                                    ns_in = NS_STOP;
                                 end
                              end
                              NS_DIGITS: begin
                                 if (dig) begin
                                    v = {4'd0, ac} * 19'd10 + {15'd0, c[3:0]};
                                    acc_in = (v > 19'(RequestBytes)) ? 15'(RequestBytes + 1)
                                                                      : v[14:0];
                                 end else ns_in = NS_STOP;
                              end
                              default: ;
                           endcase
                        end else begin
                           for (int j = 0; j < NumCodings; j++) begin
                              if (!cf[j]) begin
                                 cprog_in[j] = cod_step(3'(j), fresh ? 4'd0 : cprog_ff[j], lc);
                                 if (cprog_in[j] == cod_len(3'(j))) cfound_in[j] = 1'b1;
                              end
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
            bcnt_in = bcnt_ff + 14'd1;
         end
      end

      if (phase_ff != PH_DEAD && last && rk != K_DONE) begin
         r  = '0;
         rk = K_MALFORMED;
      end
      if (rk == K_DONE || rk == K_MALFORMED) phase_in = PH_DEAD;
      r.kind        = rk;
      r.body_length = slen_in;
      r.chunked     = fchk_in;
      r.te_other    = fte_in;
      push          = take && (rk != K_NONE);
   end

   assign pop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         phase_ff  <= PH_REQLINE;
         bcnt_ff   <= '0;
         lpos_ff   <= '0;
         cand_ff   <= 15'h7FFF;
         hdr_ff    <= HdrNone;
         tok_ff    <= '0;
         raw_ff    <= '0;
         lead_ff   <= '0;
         lne_ff    <= '0;
         acc_ff    <= '0;
         ns_ff     <= NS_SKIP;
         slen_ff   <= '0;
         for (int j = 0; j < NumCodings; j++) cprog_ff[j] <= '0;
         cfound_ff <= '0;
         fchk_ff   <= 1'b0;
         fte_ff    <= 1'b0;
         acr_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         bcnt_ff   <= bcnt_in;
         lpos_ff   <= lpos_in;
         cand_ff   <= cand_in;
         hdr_ff    <= hdr_in;
         tok_ff    <= tok_in;
         raw_ff    <= raw_in;
         lead_ff   <= lead_in;
         lne_ff    <= lne_in;
         acc_ff    <= acc_in;
         ns_ff     <= ns_in;
         slen_ff   <= slen_in;
         cprog_ff  <= cprog_in;
         cfound_ff <= cfound_in;
         fchk_ff   <= fchk_in;
         fte_ff    <= fte_in;
         acr_ff    <= acr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) buf_ff[wr_ff] <= r;
   end

   assign rsp.valid   = (cnt_ff != 2'd0);
   assign rsp.payload = buf_ff[rd_ff];

endmodule
